[rtl/core/psdm_pkg.sv]
// Shared types, codes and helpers for the picture slot display manager.
package psdm_pkg;

    // Slot and register widths fixed by the interface
    localparam int SLOT_IDX_W     = 5;
    localparam int NUM_W          = 6;
    localparam int FRAME_W        = 32;
    localparam int SHOWN_W        = 33;
    localparam int CFG_W          = 5;
    localparam int STATUS_W       = 3;
    localparam int FTYPE_W        = 8;
    localparam int OP_W           = 2;

    localparam int SLOT_COUNT_DEF = 24;
    localparam logic [SLOT_IDX_W-1:0] NO_SLOT = 5'h18;
    localparam logic [CFG_W-1:0] BUFFERS_RESET = 5'd24;

    localparam logic [FTYPE_W-1:0] TYPE_INTRA = 8'h10;
    localparam logic [FTYPE_W-1:0] TYPE_PRED  = 8'h20;
    localparam logic [FTYPE_W-1:0] TYPE_BIDIR = 8'h30;
    localparam logic [FRAME_W-1:0] MIN_SHOWN  = 32'd3;
    localparam logic [FRAME_W-1:0] CLOCK_ENDED = 32'hFFFF_FFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    // Remainder unit: four dividend bits per cycle
    localparam int MOD_BITS       = 4;
    localparam int MOD_CYCLES     = FRAME_W / MOD_BITS;
    localparam int MOD_CNT_W      = $clog2(MOD_CYCLES);

    // Operation codes
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Fetch status codes
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WAITING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ENDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXACT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LATER   = 3'd4;

    // Slot states
    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_SHOWN = 2'd2
    } slot_state_t;

    // Work classes decided by the front
    typedef enum logic [2:0] {
        K_CHECK,
        K_COMMIT,
        K_NOP,
        K_WAIT,
        K_END,
        K_SCAN
    } kind_t;

    // One classified item: key is the frame id or the clock frame
    typedef struct packed {
        kind_t                kind;
        logic [FRAME_W-1:0]   key;
        logic                 rotate;
        logic                 low;
    } item_t;

    // One result item
    typedef struct packed {
        logic                  slot_busy;
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  picture_valid;
        logic [SHOWN_W-1:0]    shown_frame_plus_one;
    } result_t;

    // Advance a restoring remainder by MOD_BITS dividend bits
    function automatic logic [NUM_W-1:0] mod_step(
        input logic [NUM_W-1:0]    rem,
        input logic [MOD_BITS-1:0] bits,
        input logic [NUM_W-1:0]    div
    );
        logic [NUM_W:0]   t;
        logic [NUM_W-1:0] r;
        r = rem;
        for (int k = MOD_BITS - 1; k >= 0; k--)
        begin
            t = {r, bits[k]};
            if (t >= {1'b0, div})
            begin
                t = t - {1'b0, div};
            end
            r = t[NUM_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/psdm_queue.sv]
// Short item queue between the front and the back.
module psdm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psdm_pkg::item_t item_in,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output psdm_pkg::item_t item_out
);
    import psdm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign item_out = entry_reg[rd_ptr_reg];

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/psdm_front.sv]
// Front: accepts commands, classifies them and hands them to the queue.
module psdm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [psdm_pkg::OP_W-1:0]           operation,
    input  logic [psdm_pkg::FRAME_W-1:0]        frame_id,
    input  logic [psdm_pkg::FTYPE_W-1:0]        frame_type,
    input  logic signed [psdm_pkg::FRAME_W-1:0] clock_frame,
    input  logic                                first_wait,
    output logic                                push,
    output psdm_pkg::item_t                     item,
    input  logic                                queue_full
);
    import psdm_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  held_reg;
    logic  accept;
    logic [FRAME_W-1:0] clk_bits;

    assign clk_bits = $unsigned(clock_frame);
    assign busy     = held_reg && queue_full;
    assign accept   = start && !busy;
    assign push     = held_reg && !queue_full;
    assign item     = item_reg;

    // Classify the incoming command
    always_comb
    begin
        item_next.rotate = (frame_type == TYPE_INTRA) || (frame_type == TYPE_PRED);
        item_next.low    = clk_bits[FRAME_W-1] || (clk_bits < MIN_SHOWN);
        item_next.key    = frame_id;
        item_next.kind   = K_NOP;
        unique case (operation)
            OP_CHECK:  item_next.kind = K_CHECK;
            OP_COMMIT: item_next.kind = K_COMMIT;
            OP_FETCH:
            begin
                item_next.key = clk_bits;
                if (first_wait)
                begin
                    item_next.kind = K_WAIT;
                end
                else if (clk_bits == CLOCK_ENDED)
                begin
                    item_next.kind = K_END;
                end
                else
                begin
                    item_next.kind = K_SCAN;
                end
            end
            OP_NONE:   item_next.kind = K_NOP;
            default:   item_next.kind = K_NOP;
        endcase
    end

    // Hold the classified item until the queue takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= 1'b1;
        end
        else if (push)
        begin
            held_reg <= 1'b0;
        end
    end

endmodule

[rtl/core/psdm_back.sv]
// Back: slot store, remainder unit and fetch scan that carry out each item.
module psdm_back #(
    parameter int SLOT_COUNT = psdm_pkg::SLOT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [psdm_pkg::NUM_W-1:0]        n_eff,
    input  logic                              queue_empty,
    input  psdm_pkg::item_t                   queue_item,
    output logic                              queue_pop,
    output logic                              done,
    output psdm_pkg::result_t                 result,
    output logic                              drop_flag,
    output logic [psdm_pkg::SLOT_IDX_W-1:0]   ref_newer_slot,
    output logic [psdm_pkg::SLOT_IDX_W-1:0]   ref_older_slot
);
    import psdm_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_CC   = 6'b000100,
        S_SCAN = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Slot store: frames in a memory, states in flops cleared by reset
    logic [FRAME_W-1:0]    frame_mem [SLOT_COUNT];
    slot_state_t           slot_state_reg [SLOT_COUNT];
    logic [FRAME_W-1:0]    frame_rd_reg;
    logic [FRAME_W-1:0]    base_reg;
    logic [SLOT_IDX_W-1:0] newer_reg;
    logic [SLOT_IDX_W-1:0] older_reg;
    logic                  drop_reg;
    logic                  done_reg;

    item_t                 cur_reg;
    logic [FRAME_W-1:0]    dividend_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      rem_next;
    logic [MOD_CNT_W-1:0]  mod_cnt_reg;
    logic [AW-1:0]         idx_reg;
    logic [NUM_W-1:0]      rd_cnt_reg;
    logic                  ev_valid_reg;
    logic [FRAME_W-1:0]    best_reg;
    logic [AW-1:0]         pick_reg;
    logic                  found_reg;
    result_t               res_reg;

    slot_state_t           cur_state;
    logic                  slot_taken;
    logic                  commit_ok;
    logic                  rd_more;
    logic                  exact;
    logic                  older_hit;

    assign cur_state = slot_state_reg[idx_reg];
    assign slot_taken = (cur_state != SLOT_FREE);
    assign commit_ok = (cur_reg.kind == K_COMMIT) && !slot_taken;
    assign rd_more   = (rd_cnt_reg < n_eff);
    assign exact     = found_reg && (best_reg == cur_reg.key);
    assign older_hit = (frame_rd_reg <= cur_reg.key);
    assign rem_next  = mod_step(rem_reg, dividend_reg[FRAME_W-1 -: MOD_BITS], n_eff);

    assign queue_pop      = (state_reg == S_IDLE) && !queue_empty;
    assign done           = done_reg;
    assign result         = res_reg;
    assign drop_flag      = drop_reg;
    assign ref_newer_slot = newer_reg;
    assign ref_older_slot = older_reg;

    // Sequence the work of one item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    unique case (queue_item.kind)
                        K_CHECK, K_COMMIT: state_next = S_MOD;
                        K_SCAN:            state_next = S_SCAN;
                        default:           state_next = S_OUT;
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1))
                begin
                    state_next = S_CC;
                end
            end
            S_CC:   state_next = S_IDLE;
            S_SCAN:
            begin
                if (!rd_more && !ev_valid_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = S_IDLE;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Write and read the frame memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CC && commit_ok)
        begin
            frame_mem[idx_reg] <= cur_reg.key;
        end
        if (state_reg == S_SCAN && rd_more)
        begin
            frame_rd_reg <= frame_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    // Datapath: remainder, scan bookkeeping and result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cur_reg      <= queue_item;
                dividend_reg <= queue_item.key - base_reg;
                rem_reg      <= '0;
                mod_cnt_reg  <= '0;
                rd_cnt_reg   <= '0;
                best_reg     <= '0;
                pick_reg     <= '0;
                found_reg    <= 1'b0;
            end
            S_MOD:
            begin
                rem_reg      <= rem_next;
                dividend_reg <= dividend_reg << MOD_BITS;
                mod_cnt_reg  <= mod_cnt_reg + 1'b1;
                idx_reg      <= rem_next[AW-1:0];
            end
            S_CC:
            begin
                res_reg.slot_busy            <= slot_taken;
                res_reg.status               <= ST_NONE;
                res_reg.slot_index           <= SLOT_IDX_W'(idx_reg);
                res_reg.picture_valid        <= 1'b0;
                res_reg.shown_frame_plus_one <= '0;
            end
            S_SCAN:
            begin
                // Issue the next read, evaluate the slot read last cycle
                if (rd_more)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    idx_reg    <= rd_cnt_reg[AW-1:0];
                end
                if (ev_valid_reg && cur_state != SLOT_FREE && older_hit
                    && best_reg < frame_rd_reg)
                begin
                    best_reg  <= frame_rd_reg;
                    pick_reg  <= idx_reg;
                    found_reg <= 1'b1;
                end
            end
            S_FIN:
            begin
                res_reg.slot_busy     <= 1'b0;
                res_reg.status        <= exact ? ST_EXACT : (found_reg ? ST_LATER : ST_NONE);
                res_reg.slot_index    <= found_reg ? SLOT_IDX_W'(pick_reg) : '0;
                res_reg.picture_valid <= found_reg && !cur_reg.low;
                res_reg.shown_frame_plus_one <=
                    found_reg ? ({1'b0, best_reg} + SHOWN_W'(1)) : '0;
            end
            S_OUT:
            begin
                res_reg.slot_busy     <= 1'b0;
                res_reg.slot_index    <= '0;
                res_reg.picture_valid <= 1'b0;
                priority if (cur_reg.kind == K_WAIT)
                begin
                    res_reg.status               <= ST_WAITING;
                    res_reg.shown_frame_plus_one <= SHOWN_W'(1);
                end
                else if (cur_reg.kind == K_END)
                begin
                    res_reg.status               <= ST_ENDED;
                    res_reg.shown_frame_plus_one <= '0;
                end
                else
                begin
                    res_reg.status               <= ST_NONE;
                    res_reg.shown_frame_plus_one <= '0;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    // Control state: FSM, slot states, references, drop flag, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            newer_reg    <= NO_SLOT;
            older_reg    <= NO_SLOT;
            drop_reg     <= 1'b1;
            done_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_state_reg[i] <= SLOT_FREE;
            end
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= (state_reg == S_CC) || (state_reg == S_FIN)
                            || (state_reg == S_OUT);
            ev_valid_reg <= (state_reg == S_SCAN) && rd_more;

            // Claim the slot on a successful commit
            if (state_reg == S_CC && commit_ok)
            begin
                slot_state_reg[idx_reg] <= SLOT_READY;
                if (idx_reg == '0)
                begin
                    base_reg <= cur_reg.key;
                end
                if (cur_reg.rotate)
                begin
                    older_reg <= newer_reg;
                    newer_reg <= SLOT_IDX_W'(idx_reg);
                end
            end

            // Drop stale slots during the scan
            if (state_reg == S_SCAN && ev_valid_reg && cur_state != SLOT_FREE)
            begin
                if (older_hit || cur_state == SLOT_SHOWN)
                begin
                    slot_state_reg[idx_reg] <= SLOT_FREE;
                end
            end

            // Mark the chosen picture shown and update the drop flag
            if (state_reg == S_FIN)
            begin
                if (found_reg)
                begin
                    slot_state_reg[pick_reg] <= SLOT_SHOWN;
                end
                drop_reg <= !exact;
            end
        end
    end

    a_pic_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.picture_valid |->
            (res_reg.status == ST_EXACT || res_reg.status == ST_LATER))
        else $error("picture handed without a match status");

    a_exact_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status == ST_EXACT |-> !drop_reg)
        else $error("exact match left the drop flag set");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> rd_cnt_reg <= n_eff)
        else $error("scan ran past the slots in use");

    a_cc_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CC |-> $past(state_reg == S_MOD))
        else $error("slot used before the remainder finished");

endmodule

[rtl/core/picture_slot_display_manager.sv]
// Top level of the picture slot display manager: front, queue and back.
//
//  Channel  | Signals                                         | Handshake
//  ---------+-------------------------------------------------+----------------------------
//  command  | operation frame_id frame_type clock_frame        | taken when start && !busy
//           | first_wait                                      |
//  result   | slot_busy status slot_index picture_valid       | one cycle, marked by done
//           | shown_frame_plus_one drop_flag ref_newer_slot   |
//           | ref_older_slot                                  |
//  config   | cfg_data (buffers_in_use)                       | taken when cfg_valid && cfg_ready
//
// Check and commit: S_IDLE dequeues, S_MOD runs the 4-bit-per-cycle remainder unit and S_CC
// reads and updates the slot. Fetch, n being the slots in use: S_IDLE dequeues, S_SCAN makes n
// reads through the frame memory port and drains the scan, and S_FIN finishes.
// Wait, end-of-stream and no-op commands: S_IDLE dequeues and S_OUT writes the result.
// Reset clears all slot states, the references and sets the drop flag; no clearing pass.
// The result receiver cannot stall; busy rises only when the queue and front stage are full.
module picture_slot_display_manager #(
    parameter int SLOT_COUNT = psdm_pkg::SLOT_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [psdm_pkg::OP_W-1:0]           operation,
    input  logic [psdm_pkg::FRAME_W-1:0]        frame_id,
    input  logic [psdm_pkg::FTYPE_W-1:0]        frame_type,
    input  logic signed [psdm_pkg::FRAME_W-1:0] clock_frame,
    input  logic                                first_wait,
    output logic                                done,
    output logic                                slot_busy,
    output logic [psdm_pkg::STATUS_W-1:0]       status,
    output logic [psdm_pkg::SLOT_IDX_W-1:0]     slot_index,
    output logic                                picture_valid,
    output logic [psdm_pkg::SHOWN_W-1:0]        shown_frame_plus_one,
    output logic                                drop_flag,
    output logic [psdm_pkg::SLOT_IDX_W-1:0]     ref_newer_slot,
    output logic [psdm_pkg::SLOT_IDX_W-1:0]     ref_older_slot,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psdm_pkg::CFG_W-1:0]          cfg_data
);
    import psdm_pkg::*;

    logic [CFG_W-1:0] buffers_reg;
    logic [NUM_W-1:0] n_eff;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    item_t            front_item;
    item_t            q_item;
    result_t          res;

    assign cfg_ready = 1'b1;

    // Store the slots-in-use register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffers_reg <= BUFFERS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            buffers_reg <= cfg_data;
        end
    end

    // Clamp slots in use to 1..SLOT_COUNT
    always_comb
    begin
        priority if (buffers_reg == '0)
        begin
            n_eff = NUM_W'(1);
        end
        else if ({1'b0, buffers_reg} > NUM_W'(SLOT_COUNT))
        begin
            n_eff = NUM_W'(SLOT_COUNT);
        end
        else
        begin
            n_eff = {1'b0, buffers_reg};
        end
    end

    psdm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .frame_id    (frame_id),
        .frame_type  (frame_type),
        .clock_frame (clock_frame),
        .first_wait  (first_wait),
        .push        (q_push),
        .item        (front_item),
        .queue_full  (q_full)
    );

    psdm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .item_out (q_item)
    );

    psdm_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .n_eff          (n_eff),
        .queue_empty    (q_empty),
        .queue_item     (q_item),
        .queue_pop      (q_pop),
        .done           (done),
        .result         (res),
        .drop_flag      (drop_flag),
        .ref_newer_slot (ref_newer_slot),
        .ref_older_slot (ref_older_slot)
    );

    assign slot_busy            = res.slot_busy;
    assign status               = res.status;
    assign slot_index           = res.slot_index;
    assign picture_valid        = res.picture_valid;
    assign shown_frame_plus_one = res.shown_frame_plus_one;

endmodule

[sim/picture_slot_display_manager_tb.sv]
// Self-checking testbench for the picture slot display manager.
`timescale 1ns / 100ps

module picture_slot_display_manager_tb;
    import psdm_pkg::*;

    localparam int SLOT_COUNT  = SLOT_COUNT_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 220;

    // One command item as driven on the ports
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame_id;
        logic [FTYPE_W-1:0] frame_type;
        logic [FRAME_W-1:0] clock_val;
        logic               await_audio;
    } frame_cmd_t;

    // One result item as seen on the ports
    typedef struct packed {
        logic                  slot_busy;
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  picture_valid;
        logic [SHOWN_W-1:0]    shown_frame_plus_one;
        logic                  drop_flag;
        logic [SLOT_IDX_W-1:0] ref_newer_slot;
        logic [SLOT_IDX_W-1:0] ref_older_slot;
    } slot_report_t;

    // Directed row: command plus an optional hand-written expectation
    typedef struct packed {
        frame_cmd_t   cmd;
        logic         typed;
        slot_report_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0] operation = OP_CHECK;
    logic [FRAME_W-1:0] frame_id = '0;
    logic [FTYPE_W-1:0] frame_type = '0;
    logic signed [FRAME_W-1:0] clock_frame = '0;
    logic first_wait = 1'b0;
    logic done;
    logic slot_busy;
    logic [STATUS_W-1:0] status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic picture_valid;
    logic [SHOWN_W-1:0] shown_frame_plus_one;
    logic drop_flag;
    logic [SLOT_IDX_W-1:0] ref_newer_slot;
    logic [SLOT_IDX_W-1:0] ref_older_slot;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // Mirror of the slot ring and its configuration
    logic [FRAME_W-1:0]    frame_of [SLOT_COUNT];
    slot_state_t           state_of [SLOT_COUNT];
    logic [SLOT_IDX_W-1:0] newer_ref;
    logic [SLOT_IDX_W-1:0] older_ref;
    logic                  drop_now;
    logic [CFG_W-1:0]      slots_reg;

    slot_report_t slot_reports_due[$];
    stim_row_t    directed_rows[$];
    int           mismatches = 0;
    int           sender_idle_pct = 0;
    int           quiet_cycles = 0;
    logic         moved = 1'b0;
    logic [FRAME_W-1:0] play_pos = '0;

    picture_slot_display_manager dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .operation            (operation),
        .frame_id             (frame_id),
        .frame_type           (frame_type),
        .clock_frame          (clock_frame),
        .first_wait           (first_wait),
        .done                 (done),
        .slot_busy            (slot_busy),
        .status               (status),
        .slot_index           (slot_index),
        .picture_valid        (picture_valid),
        .shown_frame_plus_one (shown_frame_plus_one),
        .drop_flag            (drop_flag),
        .ref_newer_slot       (ref_newer_slot),
        .ref_older_slot       (ref_older_slot),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    always #2 clk = ~clk;

    // Work out the report for one command and advance the mirror
    function automatic slot_report_t compute_slot_report(input frame_cmd_t c);
        slot_report_t r;
        logic [FRAME_W-1:0] n;
        logic [FRAME_W-1:0] slot;
        logic [FRAME_W-1:0] best;
        int pick;
        logic found;
        logic exact;
        logic low;
        r = '0;
        n = (slots_reg == 0) ? 1 : (slots_reg > SLOT_COUNT) ? SLOT_COUNT : slots_reg;
        if (c.op == OP_CHECK || c.op == OP_COMMIT)
        begin
            slot = (c.frame_id - frame_of[0]) % n;
            r.slot_busy = state_of[slot[SLOT_IDX_W-1:0]] != SLOT_FREE;
            r.slot_index = slot[SLOT_IDX_W-1:0];
            if (c.op == OP_COMMIT && !r.slot_busy)
            begin
                // rotate references on intra and predicted pictures only
                if (c.frame_type == TYPE_INTRA || c.frame_type == TYPE_PRED)
                begin
                    older_ref = newer_ref;
                    newer_ref = slot[SLOT_IDX_W-1:0];
                end
                frame_of[slot[SLOT_IDX_W-1:0]] = c.frame_id;
                state_of[slot[SLOT_IDX_W-1:0]] = SLOT_READY;
            end
        end
        else if (c.op == OP_FETCH)
        begin
            if (c.await_audio)
            begin
                r.status = ST_WAITING;
                r.shown_frame_plus_one = SHOWN_W'(1);
            end
            else if (c.clock_val == CLOCK_ENDED)
            begin
                r.status = ST_ENDED;
            end
            else
            begin
                low = c.clock_val[FRAME_W-1] || c.clock_val < MIN_SHOWN;
                found = 1'b0;
                exact = 1'b0;
                best = '0;
                pick = 0;
                // free stale slots, remember the latest earlier picture
                for (int i = 0; i < n; i++)
                begin
                    if (state_of[i] != SLOT_FREE)
                    begin
                        if (frame_of[i] <= c.clock_val)
                        begin
                            if (best < frame_of[i])
                            begin
                                best = frame_of[i];
                                pick = i;
                                found = 1'b1;
                            end
                            state_of[i] = SLOT_FREE;
                        end
                        else if (state_of[i] == SLOT_SHOWN)
                        begin
                            state_of[i] = SLOT_FREE;
                        end
                    end
                end
                if (found)
                    state_of[pick] = SLOT_SHOWN;
                // an exact match wins over the earlier picture
                for (int i = 0; i < n; i++)
                begin
                    if (!exact && state_of[i] != SLOT_FREE && frame_of[i] == c.clock_val)
                    begin
                        state_of[i] = SLOT_SHOWN;
                        drop_now = 1'b0;
                        if (found && pick != i)
                            state_of[pick] = SLOT_FREE;
                        r.status = ST_EXACT;
                        r.slot_index = i[SLOT_IDX_W-1:0];
                        r.picture_valid = !low;
                        r.shown_frame_plus_one = {1'b0, c.clock_val} + 33'd1;
                        exact = 1'b1;
                    end
                end
                if (!exact)
                begin
                    drop_now = 1'b1;
                    if (found)
                    begin
                        r.status = ST_LATER;
                        r.slot_index = pick[SLOT_IDX_W-1:0];
                        r.picture_valid = !low;
                        r.shown_frame_plus_one = {1'b0, best} + 33'd1;
                    end
                end
            end
        end
        r.drop_flag = drop_now;
        r.ref_newer_slot = newer_ref;
        r.ref_older_slot = older_ref;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [SHOWN_W-1:0] got,
                                 input logic [SHOWN_W-1:0] want);
        mismatches++;
        $display("mismatch at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic add_row(input frame_cmd_t c, input logic typed, input slot_report_t want);
        stim_row_t row;
        row.cmd = c;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Drive one command after a random gap and hold it until taken
    task automatic issue_command(input frame_cmd_t c, input logic typed,
                                 input slot_report_t want);
        slot_report_t predicted;
        logic taken;
        while ($urandom_range(1, 100) <= sender_idle_pct)
        begin
            start      <= 1'b0;
            operation  <= OP_W'($urandom_range(0, 3));
            frame_id   <= $urandom;
            first_wait <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= c.op;
        frame_id    <= c.frame_id;
        frame_type  <= c.frame_type;
        clock_frame <= c.clock_val;
        first_wait  <= c.await_audio;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        predicted = compute_slot_report(c);
        slot_reports_due.push_back(typed ? want : predicted);
    endtask

    // Write the slot count once every report is back
    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        logic taken;
        while (slot_reports_due.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        slots_reg = value;
    endtask

    // Well-formed playback with random content, plus some noise
    task automatic run_stream(input int count);
        frame_cmd_t c;
        logic [95:0] noise;
        int roll;
        int kind;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            kind = $urandom_range(0, 19);
            c.op = OP_COMMIT;
            c.frame_id = play_pos + $urandom_range(0, 3);
            c.frame_type = (kind < 8) ? TYPE_INTRA : (kind < 14) ? TYPE_PRED :
                           (kind < 19) ? TYPE_BIDIR : FTYPE_W'($urandom_range(0, 255));
            c.clock_val = $urandom;
            c.await_audio = ($urandom_range(0, 15) == 0);
            if (roll < 12)
            begin
                c.op = OP_CHECK;
            end
            else if (roll >= 45 && roll < 88)
            begin
                c.op = OP_FETCH;
                c.clock_val = play_pos + $urandom_range(0, 2) - 1;
                play_pos = play_pos + $urandom_range(0, 2);
            end
            else if (roll >= 88)
            begin
                // noise: any operation, any field, odd clock values
                noise = {$urandom, $urandom, $urandom};
                c = noise[$bits(frame_cmd_t)-1:0];
                kind = $urandom_range(0, 3);
                if (kind == 0)
                    c.clock_val = CLOCK_ENDED;
                else if (kind == 1)
                    c.clock_val[FRAME_W-1] = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    play_pos = play_pos + $urandom_range(0, 40);
            end
            issue_command(c, 1'b0, '0);
        end
        start <= 1'b0;
    endtask

    // Check each result against the oldest expectation
    always @(negedge clk)
    begin
        slot_report_t got;
        slot_report_t want;
        moved = (start && !busy) || done || (cfg_valid && cfg_ready);
        if (rst_n && done)
        begin
            got = {slot_busy, status, slot_index, picture_valid, shown_frame_plus_one,
                   drop_flag, ref_newer_slot, ref_older_slot};
            if (slot_reports_due.size() == 0)
            begin
                flag_mismatch("result with nothing pending, shown", got.shown_frame_plus_one,
                              '0);
            end
            else
            begin
                want = slot_reports_due.pop_front();
                if (got.slot_busy !== want.slot_busy)
                    flag_mismatch("slot_busy", SHOWN_W'(got.slot_busy),
                                  SHOWN_W'(want.slot_busy));
                if (got.status !== want.status)
                    flag_mismatch("status", SHOWN_W'(got.status), SHOWN_W'(want.status));
                if (got.slot_index !== want.slot_index)
                    flag_mismatch("slot_index", SHOWN_W'(got.slot_index),
                                  SHOWN_W'(want.slot_index));
                if (got.picture_valid !== want.picture_valid)
                    flag_mismatch("picture_valid", SHOWN_W'(got.picture_valid),
                                  SHOWN_W'(want.picture_valid));
                if (got.shown_frame_plus_one !== want.shown_frame_plus_one)
                    flag_mismatch("shown_frame_plus_one", got.shown_frame_plus_one,
                                  want.shown_frame_plus_one);
                if (got.drop_flag !== want.drop_flag)
                    flag_mismatch("drop_flag", SHOWN_W'(got.drop_flag),
                                  SHOWN_W'(want.drop_flag));
                if (got.ref_newer_slot !== want.ref_newer_slot)
                    flag_mismatch("ref_newer_slot", SHOWN_W'(got.ref_newer_slot),
                                  SHOWN_W'(want.ref_newer_slot));
                if (got.ref_older_slot !== want.ref_older_slot)
                    flag_mismatch("ref_older_slot", SHOWN_W'(got.ref_older_slot),
                                  SHOWN_W'(want.ref_older_slot));
            end
        end
    end

    // Stop a run that has gone quiet
    always @(posedge clk)
    begin
        if (moved)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] cfg_pick;
        logic [FRAME_W-1:0] base;
        int idle;

        // mirror starts from the reset state
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            frame_of[i] = '0;
            state_of[i] = SLOT_FREE;
        end
        newer_ref = NO_SLOT;
        older_ref = NO_SLOT;
        drop_now = 1'b1;
        slots_reg = BUFFERS_RESET;

        // reset state, wait, end of stream, no-op, first commits
        add_row({OP_CHECK, 32'd0, 8'h00, 32'd0, 1'b0}, 1'b1,
                {1'b0, ST_NONE, 5'd0, 1'b0, 33'd0, 1'b1, NO_SLOT, NO_SLOT});
        add_row({OP_FETCH, 32'd0, 8'h00, 32'd0, 1'b1}, 1'b1,
                {1'b0, ST_WAITING, 5'd0, 1'b0, 33'd1, 1'b1, NO_SLOT, NO_SLOT});
        add_row({OP_FETCH, 32'd0, 8'h00, CLOCK_ENDED, 1'b0}, 1'b1,
                {1'b0, ST_ENDED, 5'd0, 1'b0, 33'd0, 1'b1, NO_SLOT, NO_SLOT});
        add_row({OP_NONE, 32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
                {1'b0, ST_NONE, 5'd0, 1'b0, 33'd0, 1'b1, NO_SLOT, NO_SLOT});
        add_row({OP_COMMIT, 32'd0, TYPE_INTRA, 32'd0, 1'b0}, 1'b1,
                {1'b0, ST_NONE, 5'd0, 1'b0, 33'd0, 1'b1, 5'd0, NO_SLOT});
        add_row({OP_COMMIT, 32'd0, TYPE_PRED, 32'd0, 1'b0}, 1'b1,
                {1'b1, ST_NONE, 5'd0, 1'b0, 33'd0, 1'b1, 5'd0, NO_SLOT});
        // every picture type, unknown types, top frame number
        add_row({OP_COMMIT, 32'd1, TYPE_PRED, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_COMMIT, 32'd2, TYPE_BIDIR, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_COMMIT, 32'd3, 8'hFF, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_COMMIT, 32'd4, 8'h00, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_CHECK, 32'd2, 8'h00, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_COMMIT, 32'hFFFF_FFFF, TYPE_INTRA, 32'd0, 1'b0}, 1'b0, '0);
        // frame zero freed but never chosen, then low and valid pictures
        add_row({OP_FETCH, 32'd0, 8'h00, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_FETCH, 32'd0, 8'h00, 32'd2, 1'b0}, 1'b0, '0);
        add_row({OP_FETCH, 32'd0, 8'h00, 32'd5, 1'b0}, 1'b0, '0);
        add_row({OP_COMMIT, 32'd7, TYPE_INTRA, 32'd0, 1'b0}, 1'b0, '0);
        add_row({OP_FETCH, 32'd0, 8'h00, 32'd7, 1'b0}, 1'b0, '0);
        // negative clocks compare as unsigned frame numbers
        add_row({OP_FETCH, 32'd0, 8'h00, 32'h8000_0000, 1'b0}, 1'b0, '0);
        add_row({OP_FETCH, 32'd0, 8'h00, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0);
        add_row({OP_FETCH, 32'd0, 8'h00, 32'hFFFF_FFFE, 1'b0}, 1'b0, '0);
        add_row({OP_CHECK, 32'hFFFF_FFFF, 8'h00, 32'd0, 1'b0}, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        start <= 1'b0;

        // random phases over slot counts, frame bases and sender gaps
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cfg_pick = 5'd1;
                    base = 32'd100;
                    idle = 59;
                end
                1:
                begin
                    cfg_pick = 5'd24;
                    base = 32'h7FFF_FFF0;
                    idle = 0;
                end
                2:
                begin
                    cfg_pick = 5'd0;
                    base = 32'd5000;
                    idle = 21;
                end
                3:
                begin
                    cfg_pick = 5'd31;
                    base = 32'hFFFF_FF80;
                    idle = 59;
                end
                4:
                begin
                    cfg_pick = CFG_W'($urandom_range(2, 23));
                    base = $urandom_range(0, 32'h7FFF_0000);
                    idle = 0;
                end
                5:
                begin
                    cfg_pick = CFG_W'($urandom_range(0, 31));
                    base = 32'd0;
                    idle = 21;
                end
                default:
                begin
                    cfg_pick = 5'd24;
                    base = 32'd200000;
                    idle = 59;
                end
            endcase
            write_slot_count(cfg_pick);
            play_pos = base;
            sender_idle_pct = idle;
            // clear out what earlier phases left behind
            issue_command({OP_FETCH, 32'd0, 8'h00, 32'hFFFF_FFFE, 1'b0}, 1'b0, '0);
            run_stream(PHASE_ITEMS);
        end

        while (slot_reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
